// ===== hdl/mbhrs_pkg.sv =====
`timescale 1ns / 1ps

package mbhrs_pkg;

  localparam int unsigned RegDepth   = 256;
  localparam int unsigned MaxReadQty = 31;
  localparam int unsigned AddrW      = $clog2(RegDepth);
  localparam int unsigned CountW     = 9;

  localparam logic [7:0] FcReadHolding = 8'h03;
  localparam logic [7:0] FcWriteSingle = 8'h06;
  localparam logic [7:0] ExcFlag       = 8'h80;
  localparam logic [7:0] ExcIllegalFn  = 8'h01;
  localparam logic [7:0] ExcIllegalAdr = 8'h02;
  localparam logic [7:0] ExcIllegalVal = 8'h03;

  localparam logic [CountW-1:0] RegCountReset = CountW'(RegDepth);

  // response byte source select
  localparam logic [3:0] SelFc      = 4'd0;
  localparam logic [3:0] SelFcExc   = 4'd1;
  localparam logic [3:0] SelExcCode = 4'd2;
  localparam logic [3:0] SelByteCnt = 4'd3;
  localparam logic [3:0] SelRdHi    = 4'd4;
  localparam logic [3:0] SelRdLo    = 4'd5;
  localparam logic [3:0] SelAdrHi   = 4'd6;
  localparam logic [3:0] SelAdrLo   = 4'd7;
  localparam logic [3:0] SelValHi   = 4'd8;
  localparam logic [3:0] SelValLo   = 4'd9;
  localparam logic [3:0] SelNoRsp   = 4'd10;

  typedef struct packed {
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] quantity_or_value;
  } req_t;

  typedef struct packed {
    logic [7:0] response_byte;
    logic       status;
    logic       last_byte;
  } rsp_t;

  typedef struct packed {
    logic       load_req;
    logic       write_reg;
    logic       load_out;
    logic [3:0] sel;
    logic       last;
    logic       step;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_write;
    logic qty_bad;
    logic rd_range_bad;
    logic wr_range_bad;
    logic rd_last;
    logic out_free;
  } stat_t;

endpackage

// ===== hdl/modbus_holding_register_server.sv =====
`timescale 1ns / 1ps

// modbus holding-register server for function codes 3 (read holding registers) and 6
// (write single register). one parsed request goes in, the response pdu comes out one
// byte per output item, last_byte marking the end. a request is taken in the idle state and
// decoded in the next cycle, then the sequencer sends one byte per cycle, while the output
// is not stalled, through a single output register. the next request is taken as soon
// as the last byte of the previous one is loaded into the output register. the 256 x 16
// store is a memory with one read and one write port; a per-entry valid bit cleared by
// reset makes it read as zero, so there is no clearing pass. register_count may be
// written only while the block is idle.

module modbus_holding_register_server
  import mbhrs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  req_t              in_req_i,
  // response channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rsp_t              out_rsp_o,
  // register_count write port
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: decodes the request and steps through the response bytes
  mbhrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // request register, store, range checks and output register
  mbhrs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// ===== hdl/mbhrs_dp.sv =====
`timescale 1ns / 1ps

module mbhrs_dp
  import mbhrs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  req_t              in_req_i,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_data_i,
  input  logic              out_stall_i,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  output logic              out_valid_o,
  output rsp_t              out_rsp_o
);

  logic [15:0]       mem [RegDepth];
  logic [RegDepth-1:0] valid_q;
  logic [15:0]       rdata_q;
  logic              rd_valid_q;

  req_t              req_q;
  logic [AddrW-1:0]  ptr_q, ptr_d;
  logic [4:0]        rem_q;
  logic [CountW-1:0] reg_count_q;
  logic [CountW-1:0] cnt_eff;
  logic [16:0]       rd_end;
  logic              out_valid_q;
  rsp_t              out_q;
  logic [7:0]        exc_code;
  logic [7:0]        byte_sel;
  logic [15:0]       rd_word;

  // register count capped at store depth
  assign cnt_eff = (reg_count_q > CountW'(RegDepth)) ? CountW'(RegDepth) : reg_count_q;
  assign rd_end  = {1'b0, req_q.start_address} + {1'b0, req_q.quantity_or_value};

  assign stat_o.is_read      = (req_q.function_code == FcReadHolding);
  assign stat_o.is_write     = (req_q.function_code == FcWriteSingle);
  assign stat_o.qty_bad      = (req_q.quantity_or_value == 16'd0) ||
                               (req_q.quantity_or_value > 16'(MaxReadQty));
  assign stat_o.rd_range_bad = (rd_end > 17'(cnt_eff));
  assign stat_o.wr_range_bad = ({1'b0, req_q.start_address} >= 17'(cnt_eff));
  assign stat_o.rd_last      = (rem_q == 5'd1);
  assign stat_o.out_free     = !out_valid_q || !out_stall_i;

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.load_req) begin
      ptr_d = in_req_i.start_address[AddrW-1:0];
    end else if (cmd_i.step) begin
      ptr_d = ptr_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_count_q <= RegCountReset;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      ptr_q       <= '0;
    end else begin
      ptr_q <= ptr_d;
      if (cfg_we_i) begin
        reg_count_q <= cfg_data_i;
      end
      if (cmd_i.write_reg) begin
        valid_q[req_q.start_address[AddrW-1:0]] <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // store with registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_reg) begin
      mem[req_q.start_address[AddrW-1:0]] <= req_q.quantity_or_value;
    end
    rdata_q    <= mem[ptr_d];
    rd_valid_q <= valid_q[ptr_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_req_i;
      rem_q <= in_req_i.quantity_or_value[4:0];
    end else if (cmd_i.step) begin
      rem_q <= rem_q - 5'd1;
    end
    if (cmd_i.load_out) begin
      out_q.response_byte <= byte_sel;
      out_q.status        <= (cmd_i.sel == SelNoRsp);
      out_q.last_byte     <= cmd_i.last;
    end
  end

  assign rd_word = rd_valid_q ? rdata_q : 16'd0;

  always_comb begin
    priority if (!stat_o.is_read) begin
      exc_code = ExcIllegalFn;
    end else if (stat_o.qty_bad) begin
      exc_code = ExcIllegalVal;
    end else begin
      exc_code = ExcIllegalAdr;
    end
  end

  always_comb begin
    unique case (cmd_i.sel)
      SelFc:      byte_sel = req_q.function_code;
      SelFcExc:   byte_sel = req_q.function_code | ExcFlag;
      SelExcCode: byte_sel = exc_code;
      SelByteCnt: byte_sel = {req_q.quantity_or_value[6:0], 1'b0};
      SelRdHi:    byte_sel = rd_word[15:8];
      SelRdLo:    byte_sel = rd_word[7:0];
      SelAdrHi:   byte_sel = req_q.start_address[15:8];
      SelAdrLo:   byte_sel = req_q.start_address[7:0];
      SelValHi:   byte_sel = req_q.quantity_or_value[15:8];
      SelValLo:   byte_sel = req_q.quantity_or_value[7:0];
      default:    byte_sel = 8'd0;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// ===== hdl/mbhrs_ctrl.sv =====
`timescale 1ns / 1ps

module mbhrs_ctrl
  import mbhrs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_EXC_FC   = 4'd2;
  localparam logic [3:0] S_EXC_CODE = 4'd3;
  localparam logic [3:0] S_FC       = 4'd4;
  localparam logic [3:0] S_BCNT     = 4'd5;
  localparam logic [3:0] S_RD_HI    = 4'd6;
  localparam logic [3:0] S_RD_LO    = 4'd7;
  localparam logic [3:0] S_W_AH     = 4'd8;
  localparam logic [3:0] S_W_AL     = 4'd9;
  localparam logic [3:0] S_W_VH     = 4'd10;
  localparam logic [3:0] S_W_VL     = 4'd11;
  localparam logic [3:0] S_WBAD     = 4'd12;

  logic [3:0] state_q, state_d;
  logic       emit;

  assign in_stall_o = (state_q != S_IDLE);
  assign emit       = stat_i.out_free;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.sel       = SelFc;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (stat_i.is_read) begin
          state_d = (stat_i.qty_bad || stat_i.rd_range_bad) ? S_EXC_FC : S_FC;
        end else if (stat_i.is_write) begin
          if (stat_i.wr_range_bad) begin
            state_d = S_WBAD;
          end else begin
            cmd_o.write_reg = 1'b1;
            state_d         = S_FC;
          end
        end else begin
          state_d = S_EXC_FC;
        end
      end
      S_EXC_FC: begin
        cmd_o.sel = SelFcExc;
        if (emit) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_EXC_CODE;
        end
      end
      S_EXC_CODE: begin
        cmd_o.sel  = SelExcCode;
        cmd_o.last = 1'b1;
        if (emit) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_FC: begin
        cmd_o.sel = SelFc;
        if (emit) begin
          cmd_o.load_out = 1'b1;
          state_d        = stat_i.is_read ? S_BCNT : S_W_AH;
        end
      end
      S_BCNT: begin
        cmd_o.sel = SelByteCnt;
        if (emit) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_RD_HI;
        end
      end
      S_RD_HI: begin
        cmd_o.sel = SelRdHi;
        if (emit) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_RD_LO;
        end
      end
      S_RD_LO: begin
        cmd_o.sel  = SelRdLo;
        cmd_o.last = stat_i.rd_last;
        if (emit) begin
          cmd_o.load_out = 1'b1;
          cmd_o.step     = 1'b1;
          state_d        = stat_i.rd_last ? S_IDLE : S_RD_HI;
        end
      end
      S_W_AH: begin
        cmd_o.sel = SelAdrHi;
        if (emit) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_W_AL;
        end
      end
      S_W_AL: begin
        cmd_o.sel = SelAdrLo;
        if (emit) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_W_VH;
        end
      end
      S_W_VH: begin
        cmd_o.sel = SelValHi;
        if (emit) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_W_VL;
        end
      end
      S_W_VL: begin
        cmd_o.sel  = SelValLo;
        cmd_o.last = 1'b1;
        if (emit) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_WBAD: begin
        cmd_o.sel  = SelNoRsp;
        cmd_o.last = 1'b1;
        if (emit) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== dv/modbus_holding_register_server_test.sv =====
`timescale 1ns / 1ps

module modbus_holding_register_server_test;
  import mbhrs_pkg::*;

  localparam int unsigned IdleLimit   = 3000; // cycles with no request or byte taken
  localparam int unsigned LongHold    = 400;  // long receiver hold-off
  localparam int unsigned DrainCycles = 80;   // beyond the longest response

  logic              clk_i;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  req_t              in_req    = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  rsp_t              out_rsp;
  logic              cfg_we    = 1'b0;
  logic [CountW-1:0] cfg_data  = '0;

  // shadow of the server state
  logic [15:0] shadow_regs [RegDepth] = '{default: '0};
  int unsigned count_setting = 32'(RegCountReset);

  req_t requests_to_send[$];
  rsp_t response_bytes_due[$];
  rsp_t due_byte;

  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned hold_left    = 0;
  int          send_idle_pct = 0;
  int          rcv_stall_pct = 0;
  bit          long_hold_armed = 1'b0;
  bit          long_hold_used  = 1'b0;

  modbus_holding_register_server dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned active_count();
    return (count_setting > RegDepth) ? RegDepth : count_setting;
  endfunction

  function automatic void push_byte(logic [7:0] value, logic st, logic last);
    rsp_t r;
    r.response_byte = value;
    r.status        = st;
    r.last_byte     = last;
    response_bytes_due.push_back(r);
  endfunction

  // expected response pdu of one request, updates the shadow store on a good write
  function automatic void predict_response(req_t q);
    int unsigned cnt, adr, qty;
    logic [15:0] word;
    cnt = active_count();
    adr = 32'(q.start_address);
    qty = 32'(q.quantity_or_value);
    if (q.function_code == FcReadHolding) begin
      if (qty == 0 || qty > MaxReadQty) begin
        push_byte(q.function_code | ExcFlag, 1'b0, 1'b0);
        push_byte(ExcIllegalVal, 1'b0, 1'b1);
      end else if (adr + qty > cnt) begin
        push_byte(q.function_code | ExcFlag, 1'b0, 1'b0);
        push_byte(ExcIllegalAdr, 1'b0, 1'b1);
      end else begin
        push_byte(q.function_code, 1'b0, 1'b0);
        push_byte(8'(qty * 2), 1'b0, 1'b0);
        for (int unsigned i = 0; i < qty; i++) begin
          word = shadow_regs[AddrW'(adr + i)];
          push_byte(word[15:8], 1'b0, 1'b0);
          push_byte(word[7:0], 1'b0, (i + 1 == qty));
        end
      end
    end else if (q.function_code == FcWriteSingle) begin
      if (adr >= cnt) begin
        push_byte(8'h00, 1'b1, 1'b1);
      end else begin
        shadow_regs[AddrW'(adr)] = q.quantity_or_value;
        push_byte(q.function_code, 1'b0, 1'b0);
        push_byte(q.start_address[15:8], 1'b0, 1'b0);
        push_byte(q.start_address[7:0], 1'b0, 1'b0);
        push_byte(q.quantity_or_value[15:8], 1'b0, 1'b0);
        push_byte(q.quantity_or_value[7:0], 1'b0, 1'b1);
      end
    end else begin
      push_byte(q.function_code | ExcFlag, 1'b0, 1'b0);
      push_byte(ExcIllegalFn, 1'b0, 1'b1);
    end
  endfunction

  function automatic req_t make_request(logic [7:0] fc, logic [15:0] adr, logic [15:0] qv);
    req_t q;
    q.function_code     = fc;
    q.start_address     = adr;
    q.quantity_or_value = qv;
    return q;
  endfunction

  // mostly in-range reads and writes so reads return written data
  function automatic req_t random_request();
    req_t q;
    int unsigned cnt, pick, qty;
    cnt = active_count();
    q.function_code     = FcReadHolding;
    q.start_address     = 16'($urandom);
    q.quantity_or_value = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 40) begin
      q.function_code = FcWriteSingle;
      if (cnt > 0)
        q.start_address = 16'($urandom_range(cnt - 1));
    end else if (pick < 80) begin
      if (cnt > 0) begin
        qty = $urandom_range((cnt < MaxReadQty) ? cnt : MaxReadQty, 1);
        q.start_address = 16'($urandom_range(cnt - qty));
      end else begin
        qty = $urandom_range(MaxReadQty, 1);
        q.start_address = 16'($urandom_range(MaxReadQty));
      end
      q.quantity_or_value = 16'(qty);
    end else if (pick < 88) begin
      // bad quantity
      if ($urandom_range(1))
        q.quantity_or_value = 16'd0;
      else
        q.quantity_or_value = 16'($urandom_range(65535, MaxReadQty + 1));
    end else if (pick < 94) begin
      // random address, mostly past the end, read or write
      if ($urandom_range(1))
        q.function_code = FcWriteSingle;
      else
        q.quantity_or_value = 16'($urandom_range(MaxReadQty, 1));
    end else begin
      q.function_code = 8'($urandom);
    end
    return q;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_req   <= '0;
    end else begin
      if (in_valid && !in_stall)
        predict_response(in_req);
      if (!in_valid || !in_stall) begin
        if (requests_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_req   <= requests_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (response_bytes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected response: byte %h status %b last %b",
                     out_rsp.response_byte, out_rsp.status, out_rsp.last_byte);
        end else begin
          due_byte = response_bytes_due.pop_front();
          if (out_rsp.response_byte !== due_byte.response_byte ||
              out_rsp.status !== due_byte.status ||
              out_rsp.last_byte !== due_byte.last_byte) begin
            mismatches++;
            if (mismatches <= 10)
              $display("response mismatch: expected byte %h status %b last %b, got %h %b %b",
                       due_byte.response_byte, due_byte.status, due_byte.last_byte,
                       out_rsp.response_byte, out_rsp.status, out_rsp.last_byte);
          end
        end
      end
      if (long_hold_armed && !long_hold_used) begin
        long_hold_used <= 1'b1;
        hold_left      <= LongHold;
        out_stall      <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_stall_pct);
      end
    end
  end

  // watchdog on progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic write_register_count(input logic [CountW-1:0] value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we        <= 1'b0;
    count_setting = 32'(value);
  endtask

  task automatic wait_drained();
    while (requests_to_send.size() > 0 || in_valid || response_bytes_due.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned items, input int send_pct, input int rcv_pct);
    send_idle_pct = send_pct;
    rcv_stall_pct = rcv_pct;
    repeat (items) requests_to_send.push_back(random_request());
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, register_count at its reset value
    requests_to_send.push_back(make_request(FcWriteSingle, 16'd0, 16'hFFFF));
    requests_to_send.push_back(make_request(FcWriteSingle, 16'd255, 16'h8001));
    requests_to_send.push_back(make_request(FcWriteSingle, 16'd1, 16'h1234));
    requests_to_send.push_back(make_request(FcReadHolding, 16'd0, 16'd2));
    requests_to_send.push_back(make_request(FcReadHolding, 16'd225, 16'd31));
    requests_to_send.push_back(make_request(FcReadHolding, 16'd226, 16'd31));
    requests_to_send.push_back(make_request(FcReadHolding, 16'd0, 16'd0));
    requests_to_send.push_back(make_request(FcReadHolding, 16'd0, 16'd32));
    // bad quantity wins over bad address
    requests_to_send.push_back(make_request(FcReadHolding, 16'hFFFF, 16'hFFFF));
    requests_to_send.push_back(make_request(FcReadHolding, 16'hFFFF, 16'd1));
    requests_to_send.push_back(make_request(FcWriteSingle, 16'd256, 16'hABCD));
    requests_to_send.push_back(make_request(FcWriteSingle, 16'hFFFF, 16'hFFFF));
    requests_to_send.push_back(make_request(8'h00, 16'h0000, 16'h0000));
    requests_to_send.push_back(make_request(8'hFF, 16'hFFFF, 16'hFFFF));
    requests_to_send.push_back(make_request(8'h83, 16'd0, 16'd1));
    requests_to_send.push_back(make_request(8'h04, 16'd0, 16'd1));
    requests_to_send.push_back(make_request(FcReadHolding, 16'd255, 16'd1));
    requests_to_send.push_back(make_request(FcWriteSingle, 16'd128, 16'hA5A5));
    requests_to_send.push_back(make_request(FcReadHolding, 16'd127, 16'd3));
    wait_drained();

    // count above the store depth clamps to the depth
    write_register_count(9'd511);
    requests_to_send.push_back(make_request(FcReadHolding, 16'd250, 16'd6));
    requests_to_send.push_back(make_request(FcReadHolding, 16'd250, 16'd7));
    requests_to_send.push_back(make_request(FcWriteSingle, 16'd256, 16'h5A5A));
    random_phase(50, 0, 0);
    wait_drained();

    // empty store, every read and write fails
    write_register_count(9'd0);
    random_phase(20, 60, 0);
    wait_drained();

    // receiver stalls, with one long hold-off so the server backs up
    write_register_count(9'd40);
    random_phase(55, 0, 60);
    long_hold_armed = 1'b1;
    wait_drained();

    write_register_count(9'd256);
    random_phase(55, 32, 32);
    wait_drained();

    write_register_count(9'd1);
    random_phase(20, 32, 32);
    wait_drained();

    if (mismatches == 0 && response_bytes_due.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mbhrs_pkg.sv
hdl/mbhrs_dp.sv
hdl/mbhrs_ctrl.sv
hdl/modbus_holding_register_server.sv
dv/modbus_holding_register_server_test.sv
